// ===== hdl/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the sorted range search block
// Field widths, opcodes, register indexes and the probe compare result.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 10;
    localparam int LENGTH_W     = 11;
    localparam int CFG_INDEX_W  = 1;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 24;

    // input item kinds (carried on s_tuser)
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DESCENDING  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIST_LENGTH = 1'b1;

    // outcome of one probe against the key
    typedef struct packed {
        logic hit;      // probe equals key
        logic go_low;   // keep the lower half: hi <= mid
    } probe_result_t;

endpackage

// ===== hdl/srs_ram.sv =====
// ----------------------------------------------------------------------------
// srs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/srs_probe_unit.sv =====
// ----------------------------------------------------------------------------
// srs_probe_unit: shared compare unit of the binary search
// Compares one list entry with the key and picks the half to keep.
// ----------------------------------------------------------------------------
module srs_probe_unit
    import srs_pkg::*;
(
    input  logic [VALUE_W-1:0] probe,
    input  logic [VALUE_W-1:0] key,
    input  logic               descending,
    input  logic               toward_low,
    output probe_result_t      result
);

    logic equal;
    logic probe_gt;
    logic probe_lt;

    always_comb
    begin
        equal    = (probe == key);
        probe_gt = ($signed(probe) > $signed(key));
        probe_lt = ($signed(probe) < $signed(key));
        result.hit = equal;
        if (equal)
        begin
            result.go_low = toward_low;
        end
        else if (descending)
        begin
            result.go_low = probe_lt;
        end
        else
        begin
            result.go_low = probe_gt;
        end
    end

endmodule

// ===== hdl/sorted_range_search.sv =====
// ----------------------------------------------------------------------------
// sorted_range_search: first and last occurrence of a value in a sorted list
// Binary search over a RAM-held list, one probe per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one transfer per item. s_tuser is the opcode: load
//   writes data_value at entry_index into the list RAM (no result), query
//   searches the first list_length entries for data_value. s_tlast is the
//   batch marker, echoed on m_tlast of the query result.
//   Master stream (m_*): one transfer per query: found, first and last index.
//   Config channel (cfg_*): always ready; index 0 = descending, 1 = list_length.
//   Write it only while no query is in flight.
// Timing:
//   A load leaves the block idle and s_tready high for the next item.
//   A query runs two binary searches (first, then last occurrence) through
//   one compare unit and one RAM read port, one probe per cycle, with up to
//   P = ceil(log2(len+1)) probes per pass. A miss skips the second pass.
//   s_tready is low for the whole query and rises with m_tvalid, so the
//   next item is taken only once the result is in the output register.
// Reset clears registers (descending = 0, list_length = 0) and the control
//   state; list RAM contents are undefined until loaded.
// If the master side stalls, the result waits in the output register; the
//   block takes loads meanwhile and holds the next query result until free.
// ----------------------------------------------------------------------------
module sorted_range_search
    import srs_pkg::*;
#(
    parameter int LIST_DEPTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] entry_index, [41:10] data_value, pad
    input  logic                   s_tuser,   // [0] opcode
    input  logic                   s_tlast,   // batch_last
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] found, [10:1] first, [20:11] last, pad
    output logic                   m_tlast,   // result_last
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LENGTH_W-1:0]    cfg_data
);

    localparam int AW = $clog2(LIST_DEPTH);       // RAM address width
    localparam int LW = $clog2(LIST_DEPTH + 1);   // holds 0..LIST_DEPTH

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,   // issue first probe of a pass (or end an empty pass)
        S_PROBE,   // compare returning entry, issue next probe
        S_DONE     // wait for a free output register
    } state_t;

    state_t                state_reg;
    logic                  descending_reg;
    logic [LENGTH_W-1:0]   list_length_reg;
    logic [VALUE_W-1:0]    key_reg;
    logic                  batch_last_reg;
    logic [LW-1:0]         len_reg;
    logic [LW-1:0]         lo_reg;       // search window is [lo, hi)
    logic [LW-1:0]         hi_reg;
    logic [AW-1:0]         mid_reg;      // address of the entry being read
    logic [AW-1:0]         at_reg;       // last matching probe of this pass
    logic                  hit_reg;
    logic                  toward_low_reg;
    logic                  found_reg;
    logic [INDEX_W-1:0]    first_reg;
    logic [INDEX_W-1:0]    last_idx_reg;
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    // input field unpacking
    logic [INDEX_W-1:0] in_entry_index;
    logic [VALUE_W-1:0] in_data_value;
    logic               in_accept;
    logic               idx_ok;
    logic [LW-1:0]      len_sat;

    assign in_entry_index = s_tdata[INDEX_W-1:0];
    assign in_data_value  = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign s_tready       = (state_reg == S_IDLE);
    assign in_accept      = s_tvalid && s_tready;
    assign idx_ok         = (32'(in_entry_index) < 32'(LIST_DEPTH));
    assign len_sat        = (32'(list_length_reg) > 32'(LIST_DEPTH)) ?
                            LW'(LIST_DEPTH) : LW'(list_length_reg);

    // list RAM
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    assign ram_we = in_accept && (s_tuser == OP_LOAD) && idx_ok;

    srs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_entry_index)),
        .wdata (in_data_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit
    probe_result_t probe_res;

    srs_probe_unit u_probe (
        .probe      (ram_rdata),
        .key        (key_reg),
        .descending (descending_reg),
        .toward_low (toward_low_reg),
        .result     (probe_res)
    );

    // window update and next probe address
    logic          probing;
    logic [LW-1:0] lo_next;
    logic [LW-1:0] hi_next;
    logic [LW:0]   mid_sum;
    logic [AW-1:0] mid_next;
    logic          more;
    logic          pass_hit;
    logic [AW-1:0] pass_at;
    logic          out_free;
    logic          out_load;     // result moves into the output register

    always_comb
    begin
        probing = (state_reg == S_PROBE);
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (probing)
        begin
            if (probe_res.go_low)
            begin
                hi_next = LW'(mid_reg);
            end
            else
            begin
                lo_next = LW'(mid_reg) + LW'(1);
            end
        end
        // mid = lo + (hi_incl - lo) / 2 with hi_incl = hi - 1
        mid_sum  = {1'b0, lo_next} + {1'b0, hi_next} - (LW+1)'(1);
        mid_next = AW'(mid_sum >> 1);
        more     = (lo_next < hi_next);
        pass_hit = (probing && probe_res.hit) || hit_reg;
        pass_at  = (probing && probe_res.hit) ? mid_reg : at_reg;
        out_free = !m_tvalid_reg || m_tready;
        out_load = (state_reg == S_DONE) && out_free;
    end

    assign ram_raddr = mid_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg  <= 1'b0;
            list_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DESCENDING:  descending_reg  <= cfg_data[0];
                CFG_LIST_LENGTH: list_length_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tlast_reg    <= 1'b0;
            key_reg        <= '0;
            batch_last_reg <= 1'b0;
            len_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            mid_reg        <= '0;
            at_reg         <= '0;
            hit_reg        <= 1'b0;
            toward_low_reg <= 1'b1;
            found_reg      <= 1'b0;
            first_reg      <= '0;
            last_idx_reg   <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && (s_tuser == OP_QUERY))
                    begin
                        key_reg        <= in_data_value;
                        batch_last_reg <= s_tlast;
                        len_reg        <= len_sat;
                        lo_reg         <= '0;
                        hi_reg         <= len_sat;
                        hit_reg        <= 1'b0;
                        at_reg         <= '0;
                        toward_low_reg <= 1'b1;
                        state_reg      <= S_START;
                    end
                end

                S_START, S_PROBE:
                begin
                    mid_reg <= mid_next;
                    if (more)
                    begin
                        lo_reg    <= lo_next;
                        hi_reg    <= hi_next;
                        hit_reg   <= pass_hit;
                        at_reg    <= pass_at;
                        state_reg <= S_PROBE;
                    end
                    else if (toward_low_reg)
                    begin
                        if (pass_hit)
                        begin
                            // first occurrence known, search for the last one
                            first_reg      <= INDEX_W'(pass_at);
                            found_reg      <= 1'b1;
                            lo_reg         <= '0;
                            hi_reg         <= len_reg;
                            hit_reg        <= 1'b0;
                            at_reg         <= '0;
                            toward_low_reg <= 1'b0;
                            state_reg      <= S_START;
                        end
                        else
                        begin
                            found_reg    <= 1'b0;
                            first_reg    <= '0;
                            last_idx_reg <= '0;
                            state_reg    <= S_DONE;
                        end
                    end
                    else
                    begin
                        last_idx_reg <= INDEX_W'(pass_at);
                        state_reg    <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg <= {3'b000, last_idx_reg, first_reg, found_reg};
                        m_tlast_reg <= batch_last_reg;
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
